// ===== design/lba_pkg.sv =====
// Shared types and constants for the linked block allocator.
`timescale 1ns / 1ps

package lba_pkg;

   localparam int ID_W     = 7;
   localparam int LEN_W    = 7;
   localparam int BNUM_W   = 6;
   localparam int STATUS_W = 3;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_IN_USE    = 3'd1,
      ST_NO_SPACE  = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_ZERO      = 3'd4
   } status_type;

endpackage

// ===== design/lba_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/linked_block_allocator_unit.sv =====
// Linked block allocator: block chains and file table kept in two RAMs.
// Allocate: scans the block RAM read port for free blocks (up to BLOCKS), stalling when
//   the response side is not ready; one response per block, or a single error response.
// Free: walks the chain link to link and frees each of its blocks; one response.
// One request is in work at a time. After reset a clearing pass runs through both RAMs
//   before the first request is taken.
`timescale 1ns / 1ps

module linked_block_allocator_unit
   import lba_pkg::*;
#(
   parameter int BLOCKS = 64,
   parameter int FILES  = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // file_id[6:0], block_count[13:7], zero pad
   input  logic                   req_tuser,  // mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // status[2:0], block_number[8:3], zero pad
   output logic                   rsp_tlast
);

   localparam int BAW  = $clog2(BLOCKS);
   localparam int FAW  = $clog2(FILES);
   localparam int SCW  = $clog2(BLOCKS + 1);
   localparam int MAXD = (BLOCKS > FILES) ? BLOCKS : FILES;
   localparam int CW   = $clog2(MAXD);
   localparam int BWW  = BAW + 1;
   localparam int FWW  = 1 + BAW + LEN_W;

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_LOOK, S_SCAN, S_TAIL, S_WALK, S_ONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       clr_ff, clr_in;
   logic                mode_ff, mode_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [LEN_W-1:0]    cnt_ff, cnt_in;
   logic [SCW-1:0]      free_ff, free_in;
   logic [SCW-1:0]      scan_ff, scan_in;
   logic                pend_ff, pend_in;
   logic [BAW-1:0]      pend_addr_ff, pend_addr_in;
   logic [LEN_W-1:0]    taken_ff, taken_in;
   logic [BAW-1:0]      prev_ff, prev_in;
   logic [BAW-1:0]      head_ff, head_in;
   status_type          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [BNUM_W-1:0]   rsp_block_ff, rsp_block_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                blk_wr_en, blk_rd_en;
   logic [BAW-1:0]      blk_wr_addr, blk_rd_addr;
   logic [BWW-1:0]      blk_wr_data, blk_rd_data;
   logic                file_wr_en, file_rd_en;
   logic [FAW-1:0]      file_wr_addr, file_rd_addr;
   logic [FWW-1:0]      file_wr_data, file_rd_data;

   logic                blk_used_rd;
   logic [BAW-1:0]      blk_link_rd;
   logic                file_live_rd;
   logic [BAW-1:0]      file_head_rd;
   logic [LEN_W-1:0]    file_len_rd;
   logic                slot_ok, hit, id_ok, is_last;

   lba_ram #(.WIDTH(BWW), .DEPTH(BLOCKS)) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_wr_en),
      .wr_addr (blk_wr_addr),
      .wr_data (blk_wr_data),
      .rd_en   (blk_rd_en),
      .rd_addr (blk_rd_addr),
      .rd_data (blk_rd_data)
   );

   lba_ram #(.WIDTH(FWW), .DEPTH(FILES)) u_file_ram (
      .clock   (clock),
      .wr_en   (file_wr_en),
      .wr_addr (file_wr_addr),
      .wr_data (file_wr_data),
      .rd_en   (file_rd_en),
      .rd_addr (file_rd_addr),
      .rd_data (file_rd_data)
   );

   assign blk_used_rd  = blk_rd_data[BAW];
   assign blk_link_rd  = blk_rd_data[BAW-1:0];
   assign file_live_rd = file_rd_data[FWW-1];
   assign file_head_rd = file_rd_data[BAW+LEN_W-1:LEN_W];
   assign file_len_rd  = file_rd_data[LEN_W-1:0];

   assign slot_ok = !rsp_valid_ff || rsp_tready;
   assign hit     = pend_ff && !blk_used_rd;
   assign id_ok   = int'(id_ff) < FILES;
   assign is_last = (taken_ff + LEN_W'(1)) == cnt_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - BNUM_W - STATUS_W)'(0), rsp_block_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      id_in         = id_ff;
      cnt_in        = cnt_ff;
      free_in       = free_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      taken_in      = taken_ff;
      prev_in       = prev_ff;
      head_in       = head_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_last_in   = rsp_last_ff;

      blk_wr_en     = 1'b0;
      blk_wr_addr   = prev_ff;
      blk_wr_data   = '0;
      blk_rd_en     = 1'b0;
      blk_rd_addr   = BAW'(scan_ff);
      file_wr_en    = 1'b0;
      file_wr_addr  = FAW'(id_ff);
      file_wr_data  = '0;
      file_rd_en    = 1'b0;
      file_rd_addr  = FAW'(req_tdata[ID_W-1:0]);

      unique case (state_ff)
         S_CLR: begin
            blk_wr_en    = int'(clr_ff) < BLOCKS;
            blk_wr_addr  = BAW'(clr_ff);
            file_wr_en   = int'(clr_ff) < FILES;
            file_wr_addr = FAW'(clr_ff);
            clr_in       = clr_ff + CW'(1);
            if (clr_ff == CW'(MAXD - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in    = req_tuser;
               id_in      = req_tdata[ID_W-1:0];
               cnt_in     = req_tdata[ID_W+LEN_W-1:ID_W];
               file_rd_en = 1'b1;
               state_in   = S_LOOK;
            end
         end
         S_LOOK: begin
            scan_in  = '0;
            pend_in  = 1'b0;
            taken_in = '0;
            if (mode_ff == MODE_ALLOC) begin
               priority if (!id_ok) begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_ONE;
               end else if (file_live_rd) begin
                  status_in = ST_IN_USE;
                  state_in  = S_ONE;
               end else if (cnt_ff == '0) begin
                  status_in = ST_ZERO;
                  state_in  = S_ONE;
               end else if (int'(cnt_ff) > int'(free_ff)) begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_ONE;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               if (!id_ok || !file_live_rd) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_ONE;
               end else begin
                  file_wr_en   = 1'b1;
                  file_wr_data = {1'b0, file_head_rd, file_len_rd};
                  free_in      = free_ff + SCW'(file_len_rd);
                  cnt_in       = file_len_rd;
                  prev_in      = file_head_rd;
                  blk_rd_en    = 1'b1;
                  blk_rd_addr  = file_head_rd;
                  status_in    = ST_OK;
                  state_in     = S_WALK;
               end
            end
         end
         S_SCAN: begin
            if (!(hit && !slot_ok)) begin
               blk_rd_en    = int'(scan_ff) < BLOCKS;
               pend_in      = int'(scan_ff) < BLOCKS;
               pend_addr_in = BAW'(scan_ff);
               if (int'(scan_ff) < BLOCKS) begin
                  scan_in = scan_ff + SCW'(1);
               end
            end
            if (hit && slot_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_block_in  = BNUM_W'(pend_addr_ff);
               rsp_last_in   = is_last;
               if (taken_ff == '0) begin
                  head_in = pend_addr_ff;
               end else begin
                  blk_wr_en   = 1'b1;
                  blk_wr_addr = prev_ff;
                  blk_wr_data = {1'b1, pend_addr_ff};
               end
               prev_in  = pend_addr_ff;
               taken_in = taken_ff + LEN_W'(1);
               if (is_last) begin
                  pend_in  = 1'b0;
                  state_in = S_TAIL;
               end
            end
         end
         S_TAIL: begin
            blk_wr_en    = 1'b1;
            blk_wr_addr  = prev_ff;
            blk_wr_data  = {1'b1, BAW'(0)};
            file_wr_en   = 1'b1;
            file_wr_data = {1'b1, head_ff, cnt_ff};
            free_in      = free_ff - SCW'(cnt_ff);
            state_in     = S_IDLE;
         end
         S_WALK: begin
            blk_wr_en   = 1'b1;
            blk_wr_addr = prev_ff;
            blk_wr_data = {1'b0, blk_link_rd};
            taken_in    = taken_ff + LEN_W'(1);
            if (is_last) begin
               state_in = S_ONE;
            end else begin
               blk_rd_en   = 1'b1;
               blk_rd_addr = blk_link_rd;
               prev_in     = blk_link_rd;
            end
         end
         S_ONE: begin
            if (slot_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_block_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         free_ff      <= SCW'(BLOCKS);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      cnt_ff        <= cnt_in;
      scan_ff       <= scan_in;
      pend_addr_ff  <= pend_addr_in;
      taken_ff      <= taken_in;
      prev_ff       <= prev_in;
      head_ff       <= head_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for linked_block_allocator_unit; predicts block chains per request.
`timescale 1ns / 1ps

module tb_top
   import lba_pkg::*;
();

   localparam int NBLK       = 64;
   localparam int NFILE      = 128;
   localparam int IDLE_LIMIT = 4000;
   localparam int TAIL_CYCLES = 2 * NBLK + 16;

   typedef struct packed {
      status_type  status;
      logic [5:0]  bnum;
      logic        last;
   } rsp_item_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // file_id[6:0], block_count[13:7], zero pad
   logic                   req_tuser  = 1'b0; // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // status[2:0], block_number[8:3], zero pad
   logic                   rsp_tlast;

   // predictor state
   bit         blk_used  [NBLK];
   logic [5:0] blk_next  [NBLK];
   bit         file_live [NFILE];
   logic [5:0] file_head [NFILE];
   logic [6:0] file_len  [NFILE];

   rsp_item_type due_rsp[$];
   int           errors;
   int           n_alloc, n_free, n_rsp;
   int           status_hits[5];
   int           idle_cycles;
   int           rsp_stall;
   bit           no_idle;
   rsp_item_type seen, want;

   linked_block_allocator_unit #(.BLOCKS(NBLK), .FILES(NFILE)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void expect_rsp(input status_type st, input logic [5:0] bnum,
                                      input logic last);
      rsp_item_type r;
      r.status = st;
      r.bnum   = bnum;
      r.last   = last;
      due_rsp.push_back(r);
      status_hits[st]++;
   endfunction

   function automatic void alloc_chain(input logic [6:0] id, input logic [6:0] cnt);
      int free_n;
      int taken;
      int prev;
      free_n = 0;
      taken  = 0;
      prev   = 0;
      n_alloc++;
      if (file_live[id]) begin
         expect_rsp(ST_IN_USE, '0, 1'b1);
         return;
      end
      if (cnt == 0) begin
         expect_rsp(ST_ZERO, '0, 1'b1);
         return;
      end
      for (int b = 0; b < NBLK; b++)
         if (!blk_used[b]) free_n++;
      if (cnt > free_n) begin
         expect_rsp(ST_NO_SPACE, '0, 1'b1);
         return;
      end
      for (int b = 0; b < NBLK && taken < cnt; b++) begin
         if (!blk_used[b]) begin
            if (taken == 0) file_head[id] = 6'(b);
            else blk_next[prev] = 6'(b);
            blk_used[b] = 1'b1;
            blk_next[b] = '0;
            taken++;
            expect_rsp(ST_OK, 6'(b), taken == cnt);
            prev = b;
         end
      end
      file_live[id] = 1'b1;
      file_len[id]  = cnt;
   endfunction

   function automatic void release_chain(input logic [6:0] id);
      int cur;
      n_free++;
      if (!file_live[id]) begin
         expect_rsp(ST_NOT_FOUND, '0, 1'b1);
         return;
      end
      cur = file_head[id];
      for (int n = 0; n < file_len[id]; n++) begin
         blk_used[cur] = 1'b0;
         cur = blk_next[cur];
      end
      file_live[id] = 1'b0;
      expect_rsp(ST_OK, '0, 1'b1);
   endfunction

   task automatic send_request(input logic mode, input logic [6:0] id, input logic [6:0] cnt);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= mode;
      req_tdata  <= {2'b00, cnt, id};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_ALLOC) alloc_chain(id, cnt);
      else release_chain(id);
   endtask

   task automatic wait_all_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int         pick;
      logic [6:0] id;
      logic [6:0] cnt;
      int         live_ids[$];
      for (int f = 0; f < NFILE; f++)
         if (file_live[f]) live_ids.push_back(f);
      pick = $urandom_range(0, 99);
      if (pick < 80 && !(pick >= 50 && live_ids.size() == 0)) begin
         if (pick < 50) begin
            do id = 7'($urandom_range(0, NFILE - 1)); while (file_live[id]);
            cnt = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(1, 8))
                                             : 7'($urandom_range(9, NBLK));
            send_request(MODE_ALLOC, id, cnt);
         end else begin
            id = 7'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
            send_request(MODE_FREE, id, 7'($urandom_range(0, 127)));
         end
      end else begin
         pick = $urandom_range(0, 3);
         unique case (pick)
            0: begin
               if (live_ids.size() != 0)
                  id = 7'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
               else
                  id = 7'($urandom_range(0, NFILE - 1));
               send_request(MODE_ALLOC, id, 7'($urandom_range(0, 127)));
            end
            1: send_request(MODE_FREE, 7'($urandom_range(0, NFILE - 1)),
                            7'($urandom_range(0, 127)));
            2: send_request(MODE_ALLOC, 7'($urandom_range(0, NFILE - 1)), 7'd0);
            default: send_request(MODE_ALLOC, 7'($urandom_range(0, NFILE - 1)),
                                  7'($urandom_range(0, 127)));
         endcase
      end
   endtask

   task automatic test_status_codes();
      send_request(MODE_FREE,  7'd0,   7'd0);
      send_request(MODE_ALLOC, 7'd0,   7'd0);
      send_request(MODE_ALLOC, 7'd127, 7'd127);
      send_request(MODE_ALLOC, 7'd3,   7'd65);
      send_request(MODE_ALLOC, 7'd5,   7'd1);
      send_request(MODE_ALLOC, 7'd5,   7'd3);
      send_request(MODE_ALLOC, 7'd5,   7'd0);
      send_request(MODE_FREE,  7'd5,   7'd127);
      send_request(MODE_FREE,  7'd5,   7'd0);
   endtask

   task automatic test_full_pool();
      send_request(MODE_ALLOC, 7'd127, 7'd64);
      send_request(MODE_ALLOC, 7'd9,   7'd1);
      send_request(MODE_FREE,  7'd127, 7'd0);
      // hold requests until the pool is quiet
      wait_all_responses();
      send_request(MODE_ALLOC, 7'd42, 7'd1);
      send_request(MODE_ALLOC, 7'd85, 7'd63);
      send_request(MODE_FREE,  7'd42, 7'd0);
      send_request(MODE_ALLOC, 7'd0,  7'd1);
      send_request(MODE_FREE,  7'd85, 7'd0);
      send_request(MODE_FREE,  7'd0,  7'd0);
   endtask

   task automatic test_fragmented_chains();
      send_request(MODE_ALLOC, 7'd10, 7'd3);
      send_request(MODE_ALLOC, 7'd11, 7'd3);
      send_request(MODE_ALLOC, 7'd12, 7'd3);
      send_request(MODE_FREE,  7'd11, 7'd0);
      send_request(MODE_ALLOC, 7'd13, 7'd5);
      send_request(MODE_FREE,  7'd10, 7'd0);
      send_request(MODE_FREE,  7'd13, 7'd0);
      send_request(MODE_FREE,  7'd12, 7'd0);
   endtask

   task automatic test_random_traffic();
      repeat (170) random_request();
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (40) random_request();
      wait_all_responses();
      no_idle = 1'b0;
   endtask

   task automatic test_release_all();
      for (int f = 0; f < NFILE; f++)
         if (file_live[f]) send_request(MODE_FREE, 7'(f), 7'($urandom_range(0, 127)));
   endtask

   // response side: random stalls, compare against the oldest expected response
   always begin
      rsp_stall = no_idle ? 0 : $urandom_range(0, 6);
      if (rsp_stall > 0) begin
         @(negedge clock);
         rsp_tready <= 1'b0;
         repeat (rsp_stall - 1) @(negedge clock);
      end
      @(negedge clock);
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      seen.status = status_type'(rsp_tdata[2:0]);
      seen.bnum   = rsp_tdata[8:3];
      seen.last   = rsp_tlast;
      n_rsp++;
      if (due_rsp.size() == 0) begin
         $error("unexpected response: status %0d block %0d last %0d",
                seen.status, seen.bnum, seen.last);
         errors++;
      end else begin
         want = due_rsp.pop_front();
         if (seen.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_tdata[2:0]);
            errors++;
         end
         if (seen.bnum !== want.bnum) begin
            $error("block_number: expected %0d, got %0d", want.bnum, seen.bnum);
            errors++;
         end
         if (seen.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, seen.last);
            errors++;
         end
         if (rsp_tdata[RSP_TDATA_W-1:9] !== '0) begin
            $error("pad: expected 0, got %0h", rsp_tdata[RSP_TDATA_W-1:9]);
            errors++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      errors  = 0;
      no_idle = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_status_codes();
      test_full_pool();
      test_fragmented_chains();
      test_random_traffic();
      test_back_to_back();
      test_release_all();

      wait_all_responses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d allocate and %0d free requests, %0d responses checked",
               n_alloc, n_free, n_rsp);
      $display("status mix: ok %0d, in use %0d, no space %0d, not found %0d, zero %0d",
               status_hits[ST_OK], status_hits[ST_IN_USE], status_hits[ST_NO_SPACE],
               status_hits[ST_NOT_FOUND], status_hits[ST_ZERO]);
      if (errors == 0 && due_rsp.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
